@@ rtl/core/gasa_pkg.sv @@
package gasa_pkg;

   localparam int NUM_SHELF_REGS = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 13;

   localparam logic [CSR_IDX_W-1:0] REG_SHELF_HEIGHT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHELF_HEIGHT_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHELF_HEIGHT_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHELF_HEIGHT_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_HEIGHT    = 3'd5;

   localparam logic [11:0] RST_SHELF_HEIGHT_0 = 12'd16;
   localparam logic [11:0] RST_SHELF_HEIGHT_1 = 12'd32;
   localparam logic [11:0] RST_SHELF_HEIGHT_2 = 12'd64;
   localparam logic [11:0] RST_SHELF_HEIGHT_3 = 12'd128;
   localparam logic [12:0] RST_PAGE_WIDTH     = 13'd256;
   localparam logic [12:0] RST_PAGE_HEIGHT    = 13'd256;

   localparam logic [1:0] ST_PLACED   = 2'd0;
   localparam logic [1:0] ST_TOO_TALL = 2'd1;
   localparam logic [1:0] ST_NO_PAGE  = 2'd2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [NUM_SHELF_REGS-1:0][11:0] shelf_height;
      logic [12:0]                     page_width;
      logic [12:0]                     page_height;
   } cfg_type;

   typedef struct packed {
      logic        opened_page;
      logic [12:0] draw_y;
      logic [12:0] draw_x;
      logic [7:0]  page_number;
      logic [1:0]  status;
   } result_type;

endpackage

@@ rtl/core/glyph_atlas_shelf_allocator_unit.sv @@
// Pipeline: an accepted request is held in the input register, then its
// placement is written into the result register, which drives rsp_tvalid;
// that move waits while the result register is full and not draining.
// Throughput: one request per cycle unless the response stalls; shelf-class
// state updates with the result register, so back-to-back requests see it.
// Reset: config returns to 16/32/64/128 shelf heights and a 256x256 page,
// no class owns a page and no page of the pool is in use.
module glyph_atlas_shelf_allocator_unit #(
   parameter int SHELF_CLASSES = 4,
   parameter int MAX_PAGES     = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [11:0] glyph_width, [23:12] glyph_height
   input  logic [gasa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [9:2] page_number, [22:10] draw_x, [35:23] draw_y,
   // [36] opened_page, [39:37] zero
   output logic [gasa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gasa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gasa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gasa_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic        s1_vld_ff, s1_vld_in;
   logic [11:0] s1_w_ff, s1_h_ff;
   logic        rsp_vld_ff, rsp_vld_in;
   result_type  rsp_ff;
   logic        req_fire;
   logic        adv;

   gasa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gasa_place #(
      .SHELF_CLASSES (SHELF_CLASSES),
      .MAX_PAGES     (MAX_PAGES)
   ) u_place (
      .clock        (clock),
      .reset        (reset),
      .fire         (adv),
      .glyph_width  (s1_w_ff),
      .glyph_height (s1_h_ff),
      .cfg          (cfg),
      .result       (result)
   );

   // advance the held request whenever the result register is free or draining
   assign adv        = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || adv;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_vld_in  = req_fire ? 1'b1 : (adv ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_w_ff <= req_tdata[11:0];
         s1_h_ff <= req_tdata[23:12];
      end
      if (adv) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

endmodule

@@ rtl/core/gasa_csr.sv @@
module gasa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gasa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gasa_pkg::CSR_DATA_W-1:0]  csr_data,
   output gasa_pkg::cfg_type                cfg
);
   import gasa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            REG_SHELF_HEIGHT_0, REG_SHELF_HEIGHT_1,
            REG_SHELF_HEIGHT_2, REG_SHELF_HEIGHT_3: begin
               cfg_in.shelf_height[csr_index[1:0]] = csr_data[11:0];
            end
            REG_PAGE_WIDTH: begin
               cfg_in.page_width = csr_data;
            end
            REG_PAGE_HEIGHT: begin
               cfg_in.page_height = csr_data;
            end
            default: begin
               // drop writes outside the register map
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shelf_height[0] <= RST_SHELF_HEIGHT_0;
         cfg_ff.shelf_height[1] <= RST_SHELF_HEIGHT_1;
         cfg_ff.shelf_height[2] <= RST_SHELF_HEIGHT_2;
         cfg_ff.shelf_height[3] <= RST_SHELF_HEIGHT_3;
         cfg_ff.page_width      <= RST_PAGE_WIDTH;
         cfg_ff.page_height     <= RST_PAGE_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/gasa_place.sv @@
module gasa_place #(
   parameter int SHELF_CLASSES = 4,
   parameter int MAX_PAGES     = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [11:0]          glyph_width,
   input  logic [11:0]          glyph_height,
   input  gasa_pkg::cfg_type    cfg,
   output gasa_pkg::result_type result
);
   import gasa_pkg::*;

   localparam int CLS_W = (SHELF_CLASSES > 1) ? $clog2(SHELF_CLASSES) : 1;
   localparam int PU_W  = $clog2(MAX_PAGES + 1);

   logic [11:0] heights [SHELF_CLASSES];

   logic [SHELF_CLASSES-1:0] has_page_ff, has_page_in;
   logic [7:0]               class_page_ff [SHELF_CLASSES];
   logic [12:0]              cursor_x_ff   [SHELF_CLASSES];
   logic [12:0]              cursor_y_ff   [SHELF_CLASSES];
   logic [PU_W-1:0]          pages_used_ff, pages_used_in;

   logic             found;
   logic [CLS_W-1:0] sel;
   logic [11:0]      sh;
   logic             has;
   logic [12:0]      cx, cy;
   logic [7:0]       pg;
   logic [12:0]      sh1;
   logic [13:0]      sum_x;
   logic             wrap;
   logic [13:0]      cy_w;
   logic [14:0]      row_end;
   logic             need_new;
   logic             full;
   logic             commit;
   logic [PU_W+7:0]  pu_ext;
   logic [7:0]       new_page;
   logic [12:0]      next_x, next_y;

   // classes past the register map have height zero and never match
   for (genvar g = 0; g < SHELF_CLASSES; g++) begin : g_height
      if (g < NUM_SHELF_REGS) begin : g_reg
         assign heights[g] = cfg.shelf_height[g];
      end else begin : g_none
         assign heights[g] = '0;
      end
   end

   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < SHELF_CLASSES; i++) begin
         if (!found && (glyph_height < heights[i])) begin
            found = 1'b1;
            sel   = CLS_W'(i);
         end
      end
   end

   assign sh      = heights[sel];
   assign has     = has_page_ff[sel];
   assign cx      = cursor_x_ff[sel];
   assign cy      = cursor_y_ff[sel];
   assign pg      = class_page_ff[sel];
   assign sh1     = {1'b0, sh} + 13'd1;
   assign sum_x   = {1'b0, cx} + {2'b00, glyph_width};
   assign wrap    = sum_x > {1'b0, cfg.page_width};
   assign cy_w    = wrap ? ({1'b0, cy} + {1'b0, sh1}) : {1'b0, cy};
   assign row_end = {1'b0, cy_w} + {2'b00, sh1};
   assign need_new = !has || (row_end > {2'b00, cfg.page_height});
   assign full    = pages_used_ff >= PU_W'(MAX_PAGES);
   assign commit  = fire && found && !(need_new && full);
   assign pu_ext  = {8'b0, pages_used_ff};
   assign new_page = pu_ext[7:0];

   always_comb begin
      if (need_new) begin
         next_x = {1'b0, glyph_width};
         next_y = '0;
      end else begin
         next_x = wrap ? {1'b0, glyph_width} : sum_x[12:0];
         next_y = cy_w[12:0];
      end
   end

   always_comb begin
      result = '0;
      if (!found) begin
         result.status = ST_TOO_TALL;
      end else if (need_new && full) begin
         result.status = ST_NO_PAGE;
      end else begin
         result.status      = ST_PLACED;
         result.opened_page = need_new;
         if (need_new) begin
            result.page_number = new_page;
         end else begin
            result.page_number = pg;
            result.draw_x      = wrap ? 13'd0 : cx;
            result.draw_y      = cy_w[12:0];
         end
      end
   end

   always_comb begin
      has_page_in   = has_page_ff;
      pages_used_in = pages_used_ff;
      if (commit && need_new) begin
         has_page_in[sel] = 1'b1;
         pages_used_in    = pages_used_ff + PU_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_page_ff   <= '0;
         pages_used_ff <= '0;
      end else begin
         has_page_ff   <= has_page_in;
         pages_used_ff <= pages_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         cursor_x_ff[sel] <= next_x;
         cursor_y_ff[sel] <= next_y;
         if (need_new) begin
            class_page_ff[sel] <= new_page;
         end
      end
   end

endmodule
